>>> sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, constants and state encodings of the vertex normal
// accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int unsigned MaxVertices = 4096;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned PosW        = 24;
  localparam int unsigned SumW        = 64;
  localparam int unsigned NrmW        = 16;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeFace = 2'd1;
  localparam logic [1:0] ModeRead = 2'd2;

  typedef struct packed {
    logic signed [SumW-1:0] x;
    logic signed [SumW-1:0] y;
    logic signed [SumW-1:0] z;
  } sum_vec_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } pos_vec_t;

  typedef struct packed {
    logic signed [NrmW-1:0] x;
    logic signed [NrmW-1:0] y;
    logic signed [NrmW-1:0] z;
    logic                   zero;
  } normal_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDA,
    S_RDB,
    S_RDC,
    S_DIFF,
    S_MUL,
    S_SRD,
    S_SWR,
    S_NRD,
    S_NLD,
    S_NWAIT,
    S_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DINIT,
    N_DSTEP,
    N_DONE
  } norm_state_e;

endpackage

>>> sv/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Per-vertex smoothed normals: position store, face normal accumulation with
// 64-bit saturation, and unit normal readout in Q1.15.
// ----------------------------------------------------------------------------
// Load word: written in the cycle it is accepted. Triangle word: accept, 3 position reads,
//   difference, cross product on one shared 25x25 multiplier, 3 read-modify-writes of the sums.
// Read word: 1-bit-per-cycle scaling, 32-step square root and three divisions;
//   the normalizer is skipped when the sum is zero.
// One word at a time; a waiting result holds back only the emit of the next read word.
// After reset the sum RAM is cleared, one entry a cycle.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MaxVertices
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               mode_i,
  input  logic [vna_pkg::IdxW-1:0] vertex_index_i,
  input  logic [vna_pkg::IdxW-1:0] corner_b_i,
  input  logic [vna_pkg::IdxW-1:0] corner_c_i,
  input  logic signed [23:0]       pos_x_i,
  input  logic signed [23:0]       pos_y_i,
  input  logic signed [23:0]       pos_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       normal_x_o,
  output logic signed [15:0]       normal_y_o,
  output logic signed [15:0]       normal_z_o,
  output logic                     zero_length_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  vna_pkg::top_state_e state_q, state_d;

  logic          accept;
  logic          ok_a, ok_b, ok_c;
  logic [AW-1:0] clr_q;
  logic [11:0]   a_q, b_q, c_q;
  logic [1:0]    j_q;
  logic [2:0]    k_q;

  vna_pkg::pos_vec_t pa_q, pb_q, pos_rd, pos_wd;
  vna_pkg::sum_vec_t sum_rd, sum_wd;
  logic signed [24:0] e1_q [3];
  logic signed [24:0] e2_q [3];
  logic signed [24:0] op1, op2;
  logic signed [49:0] prod_q, hold_q;
  logic signed [50:0] n_q [3];

  logic          pos_we, sum_we;
  logic [AW-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [AW-1:0] cur_addr;
  logic [11:0]   corner;

  logic             norm_start, norm_done;
  vna_pkg::normal_t norm_res, res_q, out_q;
  logic             out_valid_q;
  logic             sums_zero;

  function automatic logic [AW-1:0] to_addr(logic [11:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[AW-1:0];
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] s,
                                                 logic signed [50:0] n);
    logic signed [64:0] t;
    t = 65'(s) + 65'(n);
    if (t[64] != t[63]) return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return t[63:0];
  endfunction

  assign ok_a   = 32'(vertex_index_i) < 32'(MAX_VERTICES);
  assign ok_b   = 32'(corner_b_i) < 32'(MAX_VERTICES);
  assign ok_c   = 32'(corner_c_i) < 32'(MAX_VERTICES);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    case (j_q)
      2'd0:    corner = a_q;
      2'd1:    corner = b_q;
      default: corner = c_q;
    endcase
  end
  assign cur_addr = to_addr(corner);

  assign sum_wd.x  = sat_add(sum_rd.x, n_q[0]);
  assign sum_wd.y  = sat_add(sum_rd.y, n_q[1]);
  assign sum_wd.z  = sat_add(sum_rd.z, n_q[2]);
  assign sums_zero = (sum_rd.x == 0) && (sum_rd.y == 0) && (sum_rd.z == 0);

  assign pos_wd.x = pos_x_i;
  assign pos_wd.y = pos_y_i;
  assign pos_wd.z = pos_z_i;

  // cross(e1, e2) operand order: yz zy zx xz xy yx
  always_comb begin
    case (k_q)
      3'd0:    begin op1 = e1_q[1]; op2 = e2_q[2]; end
      3'd1:    begin op1 = e1_q[2]; op2 = e2_q[1]; end
      3'd2:    begin op1 = e1_q[2]; op2 = e2_q[0]; end
      3'd3:    begin op1 = e1_q[0]; op2 = e2_q[2]; end
      3'd4:    begin op1 = e1_q[0]; op2 = e2_q[1]; end
      3'd5:    begin op1 = e1_q[1]; op2 = e2_q[0]; end
      default: begin op1 = '0;      op2 = '0;      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vna_pkg::S_CLEAR: if (clr_q == AW'(MAX_VERTICES - 1)) state_d = vna_pkg::S_IDLE;
      vna_pkg::S_IDLE: begin
        if (accept) begin
          case (mode_i)
            vna_pkg::ModeFace: if (ok_a && ok_b && ok_c) state_d = vna_pkg::S_RDA;
            vna_pkg::ModeRead: state_d = ok_a ? vna_pkg::S_NRD : vna_pkg::S_EMIT;
            default:           state_d = vna_pkg::S_IDLE;
          endcase
        end
      end
      vna_pkg::S_RDA:  state_d = vna_pkg::S_RDB;
      vna_pkg::S_RDB:  state_d = vna_pkg::S_RDC;
      vna_pkg::S_RDC:  state_d = vna_pkg::S_DIFF;
      vna_pkg::S_DIFF: state_d = vna_pkg::S_MUL;
      vna_pkg::S_MUL:  if (k_q == 3'd6) state_d = vna_pkg::S_SRD;
      vna_pkg::S_SRD:  state_d = vna_pkg::S_SWR;
      vna_pkg::S_SWR:  state_d = (j_q == 2'd2) ? vna_pkg::S_IDLE : vna_pkg::S_SRD;
      vna_pkg::S_NRD:  state_d = vna_pkg::S_NLD;
      vna_pkg::S_NLD:  state_d = sums_zero ? vna_pkg::S_EMIT : vna_pkg::S_NWAIT;
      vna_pkg::S_NWAIT: if (norm_done) state_d = vna_pkg::S_EMIT;
      vna_pkg::S_EMIT: if (!out_valid_q || !out_stall_i) state_d = vna_pkg::S_IDLE;
      default:         state_d = vna_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = (state_q != vna_pkg::S_IDLE);
    pos_we     = 1'b0;
    pos_waddr  = to_addr(vertex_index_i);
    pos_raddr  = '0;
    sum_we     = 1'b0;
    sum_waddr  = cur_addr;
    sum_raddr  = cur_addr;
    norm_start = 1'b0;
    case (state_q)
      vna_pkg::S_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_q;
      end
      vna_pkg::S_IDLE: begin
        if (accept && mode_i == vna_pkg::ModeLoad && ok_a) begin
          pos_we    = 1'b1;
          sum_we    = 1'b1;
          sum_waddr = to_addr(vertex_index_i);
        end
      end
      vna_pkg::S_RDA: pos_raddr = to_addr(a_q);
      vna_pkg::S_RDB: pos_raddr = to_addr(b_q);
      vna_pkg::S_RDC: pos_raddr = to_addr(c_q);
      vna_pkg::S_SWR: sum_we = 1'b1;
      vna_pkg::S_NRD: sum_raddr = to_addr(a_q);
      vna_pkg::S_NLD: norm_start = !sums_zero;
      default: ;
    endcase
  end

  vna_ram #(.DW(3 * vna_pkg::PosW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wd),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rd)
  );

  vna_ram #(.DW(3 * vna_pkg::SumW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i ((state_q == vna_pkg::S_SWR) ? sum_wd : '0),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rd)
  );

  vna_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_start),
    .sum_i    (sum_rd),
    .done_o   (norm_done),
    .result_o (norm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vna_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vna_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == vna_pkg::S_EMIT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == vna_pkg::S_EMIT && (!out_valid_q || !out_stall_i)) out_q <= res_q;
    case (state_q)
      vna_pkg::S_IDLE: begin
        a_q   <= vertex_index_i;
        b_q   <= corner_b_i;
        c_q   <= corner_c_i;
        res_q <= '{x: '0, y: '0, z: '0, zero: 1'b1};
      end
      vna_pkg::S_RDB: pa_q <= pos_rd;
      vna_pkg::S_RDC: pb_q <= pos_rd;
      vna_pkg::S_DIFF: begin
        e1_q[0] <= 25'(pb_q.x) - 25'(pa_q.x);
        e1_q[1] <= 25'(pb_q.y) - 25'(pa_q.y);
        e1_q[2] <= 25'(pb_q.z) - 25'(pa_q.z);
        e2_q[0] <= 25'(pos_rd.x) - 25'(pb_q.x);
        e2_q[1] <= 25'(pos_rd.y) - 25'(pb_q.y);
        e2_q[2] <= 25'(pos_rd.z) - 25'(pb_q.z);
        k_q     <= 3'd0;
      end
      vna_pkg::S_MUL: begin
        prod_q <= op1 * op2;
        k_q    <= k_q + 3'd1;
        j_q    <= 2'd0;
        case (k_q)
          3'd2:    n_q[0] <= 51'(hold_q) - 51'(prod_q);
          3'd4:    n_q[1] <= 51'(hold_q) - 51'(prod_q);
          3'd6:    n_q[2] <= 51'(hold_q) - 51'(prod_q);
          default: hold_q <= prod_q;
        endcase
      end
      vna_pkg::S_SWR: j_q <= j_q + 2'd1;
      vna_pkg::S_NLD: res_q <= '{x: '0, y: '0, z: '0, zero: 1'b1};
      vna_pkg::S_NWAIT: if (norm_done) res_q <= norm_res;
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = out_q.x;
  assign normal_y_o    = out_q.y;
  assign normal_z_o    = out_q.z;
  assign zero_length_o = out_q.zero;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vna_pkg::S_CLEAR) |-> in_stall_o)
    else $error("word accepted during clearing pass");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == vna_pkg::S_EMIT))
    else $error("output loaded outside emit");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.zero) |-> (out_q.x == 0 && out_q.y == 0 && out_q.z == 0))
    else $error("zero flag with nonzero components");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.x != 16'sh8000 && out_q.y != 16'sh8000 &&
                     out_q.z != 16'sh8000))
    else $error("component at most negative code");

endmodule

>>> sv/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Single write port, single read port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalizer: magnitude scaling, sum of squares, bit-serial
// square root and restoring division to Q1.15 for each component.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  vna_pkg::sum_vec_t  sum_i,
  output logic               done_o,
  output vna_pkg::normal_t   result_o
);

  vna_pkg::norm_state_e state_q, state_d;

  logic [63:0] m_q [3];
  logic [2:0]  neg_q;
  logic [1:0]  cnt_q;
  logic [59:0] prod_q;
  logic [61:0] acc_q;
  logic [62:0] n_q;
  logic [62:0] res_q;
  logic [4:0]  k_q;
  logic [1:0]  j_q;
  logic [31:0] rem_q;
  logic [15:0] low_q;
  logic [15:0] quo_q;
  logic [3:0]  step_q;
  vna_pkg::normal_t out_q;

  logic [63:0] big;
  logic [29:0] msq;
  logic [29:0] mdv;
  logic [62:0] bitv;
  logic [62:0] trial;
  logic [30:0] len;
  logic [45:0] num;
  logic [31:0] dt;
  logic        dge;
  logic [15:0] qn;
  logic [15:0] qs;
  logic [15:0] qv;

  always_comb begin
    big = m_q[0];
    if (m_q[1] > big) big = m_q[1];
    if (m_q[2] > big) big = m_q[2];
  end

  always_comb begin
    case (cnt_q)
      2'd0:    msq = m_q[0][29:0];
      2'd1:    msq = m_q[1][29:0];
      2'd2:    msq = m_q[2][29:0];
      default: msq = '0;
    endcase
    case (j_q)
      2'd0:    mdv = m_q[0][29:0];
      2'd1:    mdv = m_q[1][29:0];
      default: mdv = m_q[2][29:0];
    endcase
  end

  assign bitv  = 63'(1) << {k_q, 1'b0};
  assign trial = res_q + bitv;
  assign len   = res_q[30:0];
  assign num   = {1'b0, mdv, 15'd0} + 46'(len >> 1);
  assign dt    = {rem_q[30:0], low_q[15]};
  assign dge   = dt >= 32'(len);
  assign qn    = {quo_q[14:0], dge};
  assign qs    = qn[15] ? 16'h7FFF : qn;

  always_comb begin
    case (j_q)
      2'd0:    qv = neg_q[0] ? 16'(-qs) : qs;
      2'd1:    qv = neg_q[1] ? 16'(-qs) : qs;
      default: qv = neg_q[2] ? 16'(-qs) : qs;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      vna_pkg::N_IDLE:  if (start_i) state_d = vna_pkg::N_SHIFT;
      vna_pkg::N_SHIFT: begin
        if (big < 64'(1) << 29 || big >= 64'(1) << 30) state_d = vna_pkg::N_SHIFT;
        else state_d = vna_pkg::N_SQ;
      end
      vna_pkg::N_SQ:    if (cnt_q == 2'd3) state_d = vna_pkg::N_SQRT;
      vna_pkg::N_SQRT:  if (k_q == 5'd0) state_d = vna_pkg::N_DINIT;
      vna_pkg::N_DINIT: state_d = vna_pkg::N_DSTEP;
      vna_pkg::N_DSTEP: begin
        if (step_q == 4'd0) begin
          state_d = (j_q == 2'd2) ? vna_pkg::N_DONE : vna_pkg::N_DINIT;
        end
      end
      vna_pkg::N_DONE:  state_d = vna_pkg::N_IDLE;
      default:          state_d = vna_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    done_o   = (state_q == vna_pkg::N_DONE);
    result_o = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vna_pkg::N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      vna_pkg::N_IDLE: begin
        if (start_i) begin
          m_q[0]   <= sum_i.x[63] ? 64'(0) - 64'(sum_i.x) : 64'(sum_i.x);
          m_q[1]   <= sum_i.y[63] ? 64'(0) - 64'(sum_i.y) : 64'(sum_i.y);
          m_q[2]   <= sum_i.z[63] ? 64'(0) - 64'(sum_i.z) : 64'(sum_i.z);
          neg_q    <= {sum_i.z[63], sum_i.y[63], sum_i.x[63]};
          out_q    <= '0;
        end
      end
      vna_pkg::N_SHIFT: begin
        if (big >= 64'(1) << 30) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (big < 64'(1) << 29) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
        cnt_q <= 2'd0;
      end
      vna_pkg::N_SQ: begin
        prod_q <= 60'(msq * msq);
        acc_q  <= (cnt_q == 2'd0) ? '0 : acc_q + 62'(prod_q);
        cnt_q  <= cnt_q + 2'd1;
        n_q    <= 63'(acc_q) + 63'(prod_q);
        res_q  <= '0;
        k_q    <= 5'd31;
      end
      vna_pkg::N_SQRT: begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
        k_q <= k_q - 5'd1;
        j_q <= 2'd0;
      end
      vna_pkg::N_DINIT: begin
        rem_q  <= 32'(num[45:16]);
        low_q  <= num[15:0];
        quo_q  <= '0;
        step_q <= 4'd15;
      end
      vna_pkg::N_DSTEP: begin
        rem_q  <= dge ? dt - 32'(len) : dt;
        low_q  <= low_q << 1;
        quo_q  <= qn;
        step_q <= step_q - 4'd1;
        if (step_q == 4'd0) begin
          case (j_q)
            2'd0:    out_q.x <= qv;
            2'd1:    out_q.y <= qv;
            default: out_q.z <= qv;
          endcase
          j_q <= j_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/vertex_normal_accumulator_test.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_test
// Self-checking bench for the vertex normal accumulator. It loads positions,
// adds triangles and reads back unit normals. A predictor in the bench keeps
// its own positions and 64-bit saturating sums and works out each Q1.15
// normal. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vertex_normal_accumulator_test;

  localparam logic [1:0] ModeSpare = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        idx;
    logic [11:0]        cb;
    logic [11:0]        cc;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               drain;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, zero_length_o;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  word_t cur = '0;

  word_t            word_q[$];
  vna_pkg::normal_t normals_due[$];

  logic signed [23:0] pos_x_m[vna_pkg::MaxVertices];
  logic signed [23:0] pos_y_m[vna_pkg::MaxVertices];
  logic signed [23:0] pos_z_m[vna_pkg::MaxVertices];
  logic signed [63:0] acc_x[vna_pkg::MaxVertices];
  logic signed [63:0] acc_y[vna_pkg::MaxVertices];
  logic signed [63:0] acc_z[vna_pkg::MaxVertices];
  bit loaded[vna_pkg::MaxVertices];
  int loaded_list[$];

  int errors = 0;
  int accepted = 0;
  int n_load = 0, n_face = 0, n_read = 0, n_zero = 0;

  always #10 clk_i = ~clk_i;

  vertex_normal_accumulator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (cur.mode),
    .vertex_index_i(cur.idx),
    .corner_b_i    (cur.cb),
    .corner_c_i    (cur.cc),
    .pos_x_i       (cur.px),
    .pos_y_i       (cur.py),
    .pos_z_i       (cur.pz),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o),
    .zero_length_o (zero_length_o)
  );

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] rem, r, bt;
    rem = n;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] q15(logic signed [63:0] s, logic [63:0] m, logic [63:0] len);
    logic [63:0] q;
    q = (m * 64'd32768 + len / 2) / len;
    if (q > 64'd32767) q = 64'd32767;
    if (s[63]) q = -q;
    return q[15:0];
  endfunction

  function automatic vna_pkg::normal_t unit_normal(int i);
    vna_pkg::normal_t r;
    logic signed [63:0] sx, sy, sz;
    logic [63:0] mx, my, mz, big, len;
    r = '0;
    sx = acc_x[i];
    sy = acc_y[i];
    sz = acc_z[i];
    if (sx == 0 && sy == 0 && sz == 0) begin
      r.zero = 1'b1;
      return r;
    end
    mx = sx[63] ? -sx : sx;
    my = sy[63] ? -sy : sy;
    mz = sz[63] ? -sz : sz;
    big = mx;
    if (my > big) big = my;
    if (mz > big) big = mz;
    while (big >= (64'd1 << 30)) begin
      big = big >> 1; mx = mx >> 1; my = my >> 1; mz = mz >> 1;
    end
    while (big < (64'd1 << 29)) begin
      big = big << 1; mx = mx << 1; my = my << 1; mz = mz << 1;
    end
    len = root64(mx * mx + my * my + mz * mz);
    r.x = q15(sx, mx, len);
    r.y = q15(sy, my, len);
    r.z = q15(sz, mz, len);
    return r;
  endfunction

  task automatic add_triangle(int a, int b, int c);
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [63:0] nx, ny, nz;
    int k[3];
    e1x = longint'(pos_x_m[b]) - longint'(pos_x_m[a]);
    e1y = longint'(pos_y_m[b]) - longint'(pos_y_m[a]);
    e1z = longint'(pos_z_m[b]) - longint'(pos_z_m[a]);
    e2x = longint'(pos_x_m[c]) - longint'(pos_x_m[b]);
    e2y = longint'(pos_y_m[c]) - longint'(pos_y_m[b]);
    e2z = longint'(pos_z_m[c]) - longint'(pos_z_m[b]);
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    k = '{a, b, c};
    foreach (k[j]) begin
      acc_x[k[j]] = sat_sum(acc_x[k[j]], nx);
      acc_y[k[j]] = sat_sum(acc_y[k[j]], ny);
      acc_z[k[j]] = sat_sum(acc_z[k[j]], nz);
    end
  endtask

  task automatic apply_word(word_t w);
    case (w.mode)
      vna_pkg::ModeLoad: begin
        pos_x_m[w.idx] = w.px;
        pos_y_m[w.idx] = w.py;
        pos_z_m[w.idx] = w.pz;
        acc_x[w.idx] = '0;
        acc_y[w.idx] = '0;
        acc_z[w.idx] = '0;
        n_load++;
      end
      vna_pkg::ModeFace: begin
        add_triangle(int'(w.idx), int'(w.cb), int'(w.cc));
        n_face++;
      end
      vna_pkg::ModeRead: begin
        normals_due.insert(normals_due.size(), unit_normal(int'(w.idx)));
        n_read++;
      end
      default: ;
    endcase
  endtask

  function automatic bit quiet();
    return accepted >= 300 && accepted < 450;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cur <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        apply_word(cur);
        accepted++;
      end
      if (word_q.size() > 0 && (quiet() || $urandom_range(99) >= 10) &&
          !(word_q[0].drain && normals_due.size() > 0)) begin
        cur <= word_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    vna_pkg::normal_t exp_n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (normals_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word x=%0d y=%0d z=%0d zero=%0b", $realtime,
                   normal_x_o, normal_y_o, normal_z_o, zero_length_o);
        end else begin
          exp_n = normals_due.pop_front();
          if (exp_n.zero) n_zero++;
          if (exp_n.x !== normal_x_o || exp_n.y !== normal_y_o ||
              exp_n.z !== normal_z_o || exp_n.zero !== zero_length_o) begin
            errors++;
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d zero=%0b", $realtime,
                     exp_n.x, exp_n.y, exp_n.z, exp_n.zero);
            $display("%0t:          actual   x=%0d y=%0d z=%0d zero=%0b", $realtime,
                     normal_x_o, normal_y_o, normal_z_o, zero_length_o);
          end
        end
      end
      out_stall_i <= quiet() ? 1'b0 : ($urandom_range(99) < 10);
    end
  end

  function automatic word_t mk(logic [1:0] md, int a, int b, int c,
                               int x, int y, int z);
    word_t w;
    w.mode = md;
    w.idx = 12'(a);
    w.cb = 12'(b);
    w.cc = 12'(c);
    w.px = 24'(x);
    w.py = 24'(y);
    w.pz = 24'(z);
    w.drain = 1'b0;
    if (md == vna_pkg::ModeLoad && !loaded[a]) begin
      loaded[a] = 1'b1;
      loaded_list.insert(loaded_list.size(), a);
    end
    return w;
  endfunction

  task automatic queue_word(word_t w);
    word_q.insert(word_q.size(), w);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(3) == 0) return $signed($urandom_range(8191)) - 4096;
    return int'($signed(24'($urandom)));
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  initial begin
    word_t w;
    int r, vi;
    for (int i = 0; i < vna_pkg::MaxVertices; i++) begin
      acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0;
      pos_x_m[i] = '0; pos_y_m[i] = '0; pos_z_m[i] = '0;
    end
    // directed opening: extreme coordinates and indices, every mode
    queue_word(mk(vna_pkg::ModeLoad, 0, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeLoad, 1, 4095, 4095, 8388607, 0, 0));
    queue_word(mk(vna_pkg::ModeLoad, 2, 0, 0, 0, 8388607, 0));
    queue_word(mk(vna_pkg::ModeLoad, 3, 0, 0, 0, 0, 8388607));
    queue_word(mk(vna_pkg::ModeLoad, 4095, 0, 0, -8388608, -8388608, -8388608));
    queue_word(mk(vna_pkg::ModeFace, 0, 1, 2, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeFace, 1, 2, 3, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeFace, 4095, 1, 2, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeFace, 0, 0, 1, 0, 0, 0));
    queue_word(mk(ModeSpare, 4095, 4095, 4095, -1, -1, -1));
    queue_word(mk(vna_pkg::ModeRead, 0, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 1, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 2, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 3, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 4095, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 100, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeLoad, 0, 0, 0, 4096, -4096, 1));
    queue_word(mk(vna_pkg::ModeRead, 0, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeFace, 2, 1, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeFace, 3, 3, 3, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 2, 0, 0, 0, 0, 0));
    queue_word(mk(vna_pkg::ModeRead, 3, 0, 0, 0, 0, 0));
    // random mesh traffic: triangles on loaded vertices, mixed with loads, reads and spare-mode words
    for (int n = 0; n < 880; n++) begin
      r = $urandom_range(99);
      if (r < 25 || loaded_list.size() < 3) begin
        vi = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(31);
        w = mk(vna_pkg::ModeLoad, vi, $urandom_range(4095), $urandom_range(4095),
               rand_coord(), rand_coord(), rand_coord());
      end else if (r < 70) begin
        w = mk(vna_pkg::ModeFace, pick_loaded(), pick_loaded(), pick_loaded(),
               rand_coord(), rand_coord(), rand_coord());
      end else if (r < 97) begin
        vi = ($urandom_range(9) == 0) ? $urandom_range(4095) : pick_loaded();
        w = mk(vna_pkg::ModeRead, vi, $urandom_range(4095), $urandom_range(4095),
               rand_coord(), rand_coord(), rand_coord());
      end else begin
        w = mk(ModeSpare, $urandom_range(4095), $urandom_range(4095),
               $urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
      end
      w.drain = (n == 200 || n == 600);
      queue_word(w);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (normals_due.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d loads, %0d triangles, %0d normal reads (%0d zero length).",
             n_load, n_face, n_read, n_zero);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for the block");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
